/* rtl/bqf_pkg.sv */
// bqf_pkg: widths, register codes, sequencer types and the microcode
// program of the biquad filter
// depends on nothing; imported by biquad_iir_filter and tb_top
package bqf_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = 18;
    localparam int DELAY_W        = 40;
    localparam int NUM_COEFS      = 5;
    localparam int CFG_IDX_W      = 3;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W   = ((PROD_W > DELAY_W) ? PROD_W : DELAY_W) + 2;

    localparam int NUM_STEPS = 5;
    localparam int STEP_W    = 3;

    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 18'sd65536;

    // saturation limits at accumulator width
    localparam logic signed [ACC_W-1:0] DLY_MAX =
        {{(ACC_W - DELAY_W + 1){1'b0}}, {(DELAY_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DLY_MIN = ~DLY_MAX;
    localparam logic signed [ACC_W-1:0] SMP_MAX =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_idx_t;

    typedef enum logic {
        MUL_X = 1'b0,
        MUL_Y = 1'b1
    } mul_src_t;

    typedef enum logic [1:0] {
        ADD_W1   = 2'd0,
        ADD_W2   = 2'd1,
        ADD_ACC  = 2'd2,
        ADD_ZERO = 2'd3
    } add_src_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        mul_src_t  mul_src;
        coef_idx_t coef;
        add_src_t  add_src;
        logic      sub;
        logic      wr_y;
        logic      wr_w1;
        logic      wr_w2;
        logic      done;
    } ucode_t;

    // one product per step through the shared multiplier
    localparam ucode_t UCODE [NUM_STEPS] = '{
        '{mul_src: MUL_X, coef: COEF_B0, add_src: ADD_W1,   sub: 1'b0,
          wr_y: 1'b0, wr_w1: 1'b0, wr_w2: 1'b0, done: 1'b0},
        '{mul_src: MUL_X, coef: COEF_B1, add_src: ADD_W2,   sub: 1'b0,
          wr_y: 1'b1, wr_w1: 1'b0, wr_w2: 1'b0, done: 1'b0},
        '{mul_src: MUL_Y, coef: COEF_A1, add_src: ADD_ACC,  sub: 1'b1,
          wr_y: 1'b0, wr_w1: 1'b1, wr_w2: 1'b0, done: 1'b0},
        '{mul_src: MUL_X, coef: COEF_B2, add_src: ADD_ZERO, sub: 1'b0,
          wr_y: 1'b0, wr_w1: 1'b0, wr_w2: 1'b0, done: 1'b0},
        '{mul_src: MUL_Y, coef: COEF_A2, add_src: ADD_ACC,  sub: 1'b1,
          wr_y: 1'b0, wr_w1: 1'b0, wr_w2: 1'b1, done: 1'b1}
    };

endpackage

/* rtl/biquad_iir_filter.sv */
// biquad_iir_filter: second-order iir section, transposed direct form ii,
// run by a five-step microcode program over one shared multiplier
// depends on bqf_pkg
//
// usage:
//   input stream s_*: s_tdata carries the sample, s_tlast marks block end.
//   output stream m_*: m_tdata carries the filtered sample, m_tlast copied.
//   cfg_*: write channel, cfg_index selects b0, b1, b2, a1, a2 (0..4),
//   cfg_data holds the 18-bit coefficient; cfg_ready is always high.
//   any coefficient write clears both delay words; other indexes are ignored.
// timing:
//   an item is taken while idle, then five steps run, one product each
//   through the single 16x18 multiplier; the result enters the output
//   register at the end of the fifth step. a new item is taken only once
//   the sequencer has finished the program and is back in idle.
//   a held result does not block acceptance; if the receiver still stalls
//   when the next item reaches its last step, that step waits.
// reset:
//   rst_n clears the delay words, loads b0 with unity and the rest with zero,
//   and empties the output register.
module biquad_iir_filter
    import bqf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [15:0] in_sample
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [15:0] out_sample
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    state_t                           state_reg, state_next;
    logic [STEP_W-1:0]                step_reg, step_next;
    logic signed [COEF_W-1:0]         coef_reg [NUM_COEFS];
    logic signed [SAMPLE_WIDTH-1:0]   x_reg;
    logic                             last_reg;
    logic signed [SAMPLE_WIDTH-1:0]   y_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [DELAY_W-1:0]        w1_reg, w2_reg;
    logic                             out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]          out_sample_reg;
    logic                             out_last_reg;

    ucode_t                           uc;
    logic                             in_take;
    logic                             cfg_take;
    logic                             cfg_hit;
    logic                             advance;
    logic                             out_load;
    logic signed [SAMPLE_WIDTH-1:0]   mul_a;
    logic signed [COEF_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]         prod;
    logic signed [ACC_W-1:0]          prod_ext;
    logic signed [ACC_W-1:0]          addend;
    logic signed [ACC_W-1:0]          sum;
    logic signed [DELAY_W-1:0]        sum_sat;
    logic signed [ACC_W-1:0]          rounded;
    logic signed [ACC_W-1:0]          y_full;
    logic signed [SAMPLE_WIDTH-1:0]   y_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = TDATA_W'(out_sample_reg);
    assign m_tlast   = out_last_reg;

    assign in_take  = s_tvalid && s_tready;
    assign cfg_take = cfg_valid && cfg_ready;
    assign uc       = UCODE[step_reg];
    assign cfg_hit  = cfg_index inside {COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2};

    // datapath
    always_comb
    begin
        mul_a    = (uc.mul_src == MUL_Y) ? y_reg : x_reg;
        mul_b    = coef_reg[uc.coef];
        prod     = mul_a * mul_b;
        prod_ext = ACC_W'(prod);
        case (uc.add_src)
            ADD_W1:  addend = ACC_W'(w1_reg);
            ADD_W2:  addend = ACC_W'(w2_reg);
            ADD_ACC: addend = acc_reg;
            default: addend = '0;
        endcase
        sum = uc.sub ? (addend - prod_ext) : (addend + prod_ext);
        if (sum > DLY_MAX)
            sum_sat = DLY_MAX[DELAY_W-1:0];
        else if (sum < DLY_MIN)
            sum_sat = DLY_MIN[DELAY_W-1:0];
        else
            sum_sat = sum[DELAY_W-1:0];
        rounded = acc_reg + RND_HALF;
        y_full  = rounded >>> COEF_FRAC_BITS;
        if (y_full > SMP_MAX)
            y_sat = SMP_MAX[SAMPLE_WIDTH-1:0];
        else if (y_full < SMP_MIN)
            y_sat = SMP_MIN[SAMPLE_WIDTH-1:0];
        else
            y_sat = y_full[SAMPLE_WIDTH-1:0];
    end

    // sequencer: last step waits while the output register is still full
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        advance    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (uc.done)
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        advance    = 1'b1;
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                end
                else
                begin
                    advance   = 1'b1;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= COEF_B0_RESET;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            coef_reg[3] <= '0;
            coef_reg[4] <= '0;
        end
        else if (cfg_take && cfg_hit)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // delay words, cleared by any coefficient write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg <= '0;
            w2_reg <= '0;
        end
        else if (cfg_take && cfg_hit)
        begin
            w1_reg <= '0;
            w2_reg <= '0;
        end
        else if (advance)
        begin
            if (uc.wr_w1)
                w1_reg <= sum_sat;
            if (uc.wr_w2)
                w2_reg <= sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg    <= s_tdata[SAMPLE_WIDTH-1:0];
            last_reg <= s_tlast;
        end
        if (advance)
        begin
            acc_reg <= sum;
            if (uc.wr_y)
                y_reg <= y_sat;
        end
        if (out_load)
        begin
            out_sample_reg <= y_reg;
            out_last_reg   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_hit |=> w1_reg == '0 && w2_reg == '0)
        else $error("delay words not cleared after coefficient write");

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_RUN && step_reg == '0)
        else $error("accepted item did not start the program");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg < STEP_W'(NUM_STEPS))
        else $error("step counter ran past the program");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && uc.done && out_valid_reg && !m_tready
        |=> state_reg == ST_RUN && $stable(step_reg) && $stable(w2_reg))
        else $error("last step did not wait for the output register");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for biquad_iir_filter, a directed table followed by
// random phases of coefficients and samples with random stalls on both streams
// depends on bqf_pkg and biquad_iir_filter
module tb_top
    import bqf_pkg::*;
();

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_AT         = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 20;
    localparam int REPORT_MAX      = 10;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(NUM_COEFS);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;

    localparam logic signed [COEF_W-1:0] COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_UNITY = COEF_B0_RESET;
    localparam logic signed [COEF_W-1:0] COEF_HALF  = COEF_B0_RESET >>> 1;
    localparam logic signed [COEF_W-1:0] COEF_M1    = '1;

    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum int {
        SET_WILD  = 0,
        SET_RAIL  = 1,
        SET_MILD  = 2,
        SET_PLAIN = 3
    } coef_set_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] y;
        logic                           lst;
    } out_item_t;

    typedef struct packed {
        logic                           is_cfg;
        logic [CFG_IDX_W-1:0]           idx;
        logic [COEF_W-1:0]              val;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        logic                           lst;
        logic                           typed;
        logic signed [SAMPLE_WIDTH-1:0] y;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;   // [15:0] in_sample
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;   // [15:0] out_sample
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    longint    taps [NUM_COEFS];
    longint    dly1;
    longint    dly2;
    out_item_t pending_y [$];
    row_t      plan [$];

    int  samples_in;
    int  samples_out;
    int  cfg_writes;
    int  mismatches;
    int  idle_cycles;
    bit  quiet;
    bit  held;

    biquad_iir_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] biquad_next(
        input logic signed [SAMPLE_WIDTH-1:0] x);
        longint xv;
        longint acc;
        longint yv;
        longint w1;
        longint w2;
        xv  = x;
        acc = xv * taps[COEF_B0] + dly1 + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        yv  = clip(acc >>> COEF_FRAC_BITS, SAMPLE_WIDTH);
        w1  = xv * taps[COEF_B1] - yv * taps[COEF_A1] + dly2;
        w2  = xv * taps[COEF_B2] - yv * taps[COEF_A2];
        dly1 = clip(w1, DELAY_W);
        dly2 = clip(w2, DELAY_W);
        return SAMPLE_WIDTH'(yv);
    endfunction

    function automatic void taps_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [COEF_W-1:0] val);
        if (idx < NUM_COEFS)
        begin
            taps[idx] = longint'($signed(val));
            dly1 = 0;
            dly2 = 0;
        end
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COEF_W-1:0] val);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        plan.push_back(r);
    endfunction

    function automatic void add_smp(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                    input logic lst, input logic typed,
                                    input logic signed [SAMPLE_WIDTH-1:0] y);
        row_t r;
        r       = '0;
        r.smp   = smp;
        r.lst   = lst;
        r.typed = typed;
        r.y     = y;
        plan.push_back(r);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return $urandom_range(0, 1) ? SMP_HI : SMP_LO;
            1:       return SAMPLE_WIDTH'(int'($urandom_range(0, 15)) - 8);
            2:       return SAMPLE_WIDTH'(int'($urandom_range(0, 2000)) - 1000);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(input coef_set_t kind,
                                                     input int idx);
        case (kind)
            SET_WILD:
                return COEF_W'($urandom);
            SET_RAIL:
                case ($urandom_range(0, 4))
                    0:       return COEF_MIN;
                    1:       return COEF_MAX;
                    2:       return '0;
                    3:       return COEF_M1;
                    default: return COEF_UNITY;
                endcase
            SET_MILD:
                if (idx == COEF_A1)
                    return COEF_W'(int'($urandom_range(0, 200000)) - 100000);
                else if (idx == COEF_A2)
                    return COEF_W'($urandom_range(0, 60000));
                else
                    return COEF_W'(int'($urandom_range(0, 65536)) - 32768);
            default:
                return (idx == COEF_B0) ? COEF_UNITY : '0;
        endcase
    endfunction

    // offer one item until taken, record what it should produce
    task automatic send_item(input logic signed [SAMPLE_WIDTH-1:0] smp,
                             input logic lst, input logic typed,
                             input logic signed [SAMPLE_WIDTH-1:0] y_typed);
        out_item_t e;
        logic signed [SAMPLE_WIDTH-1:0] y_pred;
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(smp);
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        y_pred = biquad_next(smp);
        e.y    = typed ? y_typed : y_pred;
        e.lst  = lst;
        pending_y.push_back(e);
        samples_in++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_y.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic [COEF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        taps_write(idx, val);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // output side: random stalls plus one long hold-off while input keeps coming
    initial
    begin
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!held && samples_in >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            samples_out++;
            if (pending_y.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected item: y %0d last %0b",
                             $signed(m_tdata[SAMPLE_WIDTH-1:0]), m_tlast);
            end
            else
            begin
                e = pending_y.pop_front();
                if (m_tdata[SAMPLE_WIDTH-1:0] !== e.y)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("item %0d: y expected %0d actual %0d", samples_out,
                                 e.y, $signed(m_tdata[SAMPLE_WIDTH-1:0]));
                end
                if (m_tlast !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("item %0d: last expected %0b actual %0b", samples_out,
                                 e.lst, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("** biquad_iir_filter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        coef_set_t kind;
        int        left;
        int        blk;
        bit        framed;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        samples_in  = 0;
        samples_out = 0;
        cfg_writes  = 0;
        mismatches  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        held        = 1'b0;
        taps[COEF_B0] = COEF_B0_RESET;
        taps[COEF_B1] = 0;
        taps[COEF_B2] = 0;
        taps[COEF_A1] = 0;
        taps[COEF_A2] = 0;
        dly1 = 0;
        dly2 = 0;

        // reset coefficients pass samples through unchanged
        add_smp(16'sd0, 1'b0, 1'b1, 16'sd0);
        add_smp(16'sd1, 1'b0, 1'b1, 16'sd1);
        add_smp(-16'sd1, 1'b0, 1'b1, -16'sd1);
        add_smp(SMP_HI, 1'b0, 1'b1, SMP_HI);
        add_smp(SMP_LO, 1'b0, 1'b1, SMP_LO);
        add_smp(16'sd12345, 1'b1, 1'b1, 16'sd12345);
        // gain near +2 and -2 drives the output into saturation
        add_cfg(COEF_B0, COEF_MAX);
        add_smp(SMP_HI, 1'b0, 1'b1, SMP_HI);
        add_smp(SMP_LO, 1'b0, 1'b1, SMP_LO);
        add_smp(16'sd0, 1'b1, 1'b1, 16'sd0);
        add_cfg(COEF_B0, COEF_MIN);
        add_smp(SMP_LO, 1'b0, 1'b1, SMP_HI);
        add_smp(SMP_HI, 1'b1, 1'b1, SMP_LO);
        // gain one half shows rounding of exact halves upward
        add_cfg(COEF_B0, COEF_HALF);
        add_smp(16'sd1, 1'b0, 1'b1, 16'sd1);
        add_smp(-16'sd1, 1'b0, 1'b1, 16'sd0);
        add_smp(16'sd3, 1'b0, 1'b1, 16'sd2);
        add_smp(-16'sd3, 1'b1, 1'b1, -16'sd1);
        // all taps at the rails, spare indexes must keep the delay state
        add_cfg(COEF_B0, COEF_MAX);
        add_cfg(COEF_B1, COEF_MAX);
        add_cfg(COEF_B2, COEF_MIN);
        add_cfg(COEF_A1, COEF_MIN);
        add_cfg(COEF_A2, COEF_MAX);
        add_smp(SMP_HI, 1'b0, 1'b0, '0);
        add_smp(SMP_LO, 1'b0, 1'b0, '0);
        add_smp(SMP_HI, 1'b0, 1'b0, '0);
        add_smp(16'sd20000, 1'b0, 1'b0, '0);
        add_cfg(IDX_SPARE_LO, COEF_M1);
        add_smp(SMP_LO, 1'b0, 1'b0, '0);
        add_cfg(IDX_SPARE_HI, '0);
        add_smp(16'sd1000, 1'b1, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_coef(plan[i].idx, plan[i].val);
            end
            else
                send_item(plan[i].smp, plan[i].lst, plan[i].typed, plan[i].y);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            quiet = (ph >= NUM_PHASES - 2);
            kind  = coef_set_t'(ph % 4);
            drain();
            if ($urandom_range(0, 2) == 0)
                write_coef(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                           COEF_W'($urandom));
            for (int c = 0; c < NUM_COEFS; c++)
                if (kind == SET_PLAIN || $urandom_range(0, 3) != 0)
                    write_coef(CFG_IDX_W'(c), pick_coef(kind, c));
            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                blk    = $urandom_range(1, 24);
                framed = ($urandom_range(0, 9) != 0);
                if (blk > left)
                    blk = left;
                for (int k = 0; k < blk; k++)
                    send_item(pick_sample(),
                              framed ? (k == blk - 1) : 1'($urandom_range(0, 1)),
                              1'b0, '0);
                left -= blk;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_y.size() != 0)
        begin
            $display("%0d expected items never arrived", pending_y.size());
            mismatches += pending_y.size();
        end
        $display("covered %0d samples in and %0d out over %0d coefficient phases,",
                 samples_in, samples_out, NUM_PHASES + 1);
        $display("with %0d register writes and %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0)
            $display("** biquad_iir_filter: PASSED **");
        else
            $display("** biquad_iir_filter: FAILED **");
        $finish;
    end

endmodule
